// File: rtl/sbt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source byte tokenizer package
// Shared payload types, token codes and character class helpers.
// ----------------------------------------------------------------------------
package sbt_pkg;

    localparam int KEYWORD_CHARS = 6;
    localparam int OFFSET_BITS   = 24;
    localparam int COUNT_BITS    = 16;
    localparam int WIDX_BITS     = $clog2(KEYWORD_CHARS);

    // Token kinds.
    localparam logic [5:0] K_EOF     = 6'd0;
    localparam logic [5:0] K_NEWLINE = 6'd10;
    localparam logic [5:0] K_STRING  = 6'd27;
    localparam logic [5:0] K_COMMENT = 6'd28;
    localparam logic [5:0] K_INT     = 6'd29;
    localparam logic [5:0] K_FLOAT   = 6'd30;
    localparam logic [5:0] K_VAR     = 6'd31;
    localparam logic [5:0] K_IF      = 6'd32;
    localparam logic [5:0] K_ELSE    = 6'd33;
    localparam logic [5:0] K_WHILE   = 6'd34;
    localparam logic [5:0] K_FOR     = 6'd35;
    localparam logic [5:0] K_FUNC    = 6'd36;
    localparam logic [5:0] K_RETURN  = 6'd37;
    localparam logic [5:0] K_PRINT   = 6'd38;
    localparam logic [5:0] K_BOOL    = 6'd39;
    localparam logic [5:0] K_UNKNOWN = 6'd40;
    localparam logic [5:0] K_NONE    = 6'd0;

    // Error codes.
    localparam logic [2:0] E_NONE     = 3'd0;
    localparam logic [2:0] E_CHAR     = 3'd1;
    localparam logic [2:0] E_DOT      = 3'd2;
    localparam logic [2:0] E_NUMBER   = 3'd3;
    localparam logic [2:0] E_UNTERM   = 3'd4;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    typedef logic [KEYWORD_CHARS-1:0][7:0] t_word;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in;

    typedef struct packed {
        logic [5:0]             token_kind;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [COUNT_BITS-1:0]  text_length;
        logic [COUNT_BITS-1:0]  line;
        logic [COUNT_BITS-1:0]  column;
        logic [2:0]             error_code;
        logic                   last_of_run;
    } t_out;

    function automatic logic is_digit(logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    endfunction

    function automatic logic is_word(logic [7:0] c);
        return is_alpha(c) || is_digit(c) || (c == CH_UNDER);
    endfunction

    // Single-character tokens; zero when the byte is not one.
    function automatic logic [5:0] punct_kind(logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        unique case (c)
            "(":     k = 6'd1;
            ")":     k = 6'd2;
            "{":     k = 6'd3;
            "}":     k = 6'd4;
            ";":     k = 6'd5;
            ",":     k = 6'd6;
            "%":     k = 6'd7;
            "&":     k = 6'd8;
            "|":     k = 6'd9;
            CH_LF:   k = K_NEWLINE;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Operators that may pair with a following '='.
    function automatic logic [5:0] op_kind(logic [7:0] c);
        logic [5:0] k;
        k = K_NONE;
        unique case (c)
            "=":     k = 6'd11;
            "!":     k = 6'd13;
            "<":     k = 6'd15;
            ">":     k = 6'd17;
            "+":     k = 6'd19;
            "-":     k = 6'd21;
            "*":     k = 6'd23;
            "/":     k = 6'd25;
            default: k = K_NONE;
        endcase
        return k;
    endfunction

    // Keyword lookup over the kept identifier bytes.
    function automatic logic [5:0] word_kind(t_word w, logic [COUNT_BITS-1:0] len);
        logic [5:0] k;
        k = K_VAR;
        if (len == COUNT_BITS'(2) && w[0] == "i" && w[1] == "f") begin
            k = K_IF;
        end else if (len == COUNT_BITS'(3) && w[0] == "f" && w[1] == "o" && w[2] == "r") begin
            k = K_FOR;
        end else if (len == COUNT_BITS'(4) && w[0] == "e" && w[1] == "l" && w[2] == "s"
                     && w[3] == "e") begin
            k = K_ELSE;
        end else if (len == COUNT_BITS'(4) && w[0] == "f" && w[1] == "u" && w[2] == "n"
                     && w[3] == "c") begin
            k = K_FUNC;
        end else if (len == COUNT_BITS'(4) && w[0] == "t" && w[1] == "r" && w[2] == "u"
                     && w[3] == "e") begin
            k = K_BOOL;
        end else if (len == COUNT_BITS'(5) && w[0] == "w" && w[1] == "h" && w[2] == "i"
                     && w[3] == "l" && w[4] == "e") begin
            k = K_WHILE;
        end else if (len == COUNT_BITS'(5) && w[0] == "p" && w[1] == "r" && w[2] == "i"
                     && w[3] == "n" && w[4] == "t") begin
            k = K_PRINT;
        end else if (len == COUNT_BITS'(5) && w[0] == "f" && w[1] == "a" && w[2] == "l"
                     && w[3] == "s" && w[4] == "e") begin
            k = K_BOOL;
        end else if (len == COUNT_BITS'(6) && w[0] == "r" && w[1] == "e" && w[2] == "t"
                     && w[3] == "u" && w[4] == "r" && w[5] == "n") begin
            k = K_RETURN;
        end
        return k;
    endfunction

endpackage

// File: rtl/source_byte_tokenizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Source byte tokenizer
// Streams source bytes in and gives tokens with position and error code.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid, i_in_data, o_in_stall) takes one source byte
//   or an end-of-input mark per transfer. Output channel (o_out_valid,
//   o_out_data, i_out_stall) gives tokens; last_of_run marks the last token
//   caused by one input transfer. One input transfer causes zero, one or
//   two tokens.
//   Latency: a token caused by an input transfer is offered in the next
//   cycle when the output queue is empty, otherwise after the tokens ahead
//   of it. Throughput: one input transfer per cycle while o_in_stall is low;
//   the lexer state is updated once per byte.
//   Tokens collect in a four-entry output queue. The input stalls while the
//   queue has fewer than two free entries, so a receiver stall backs up into
//   the input once three tokens wait; nothing is lost or repeated.
//   Reset empties the queue and returns the lexer to idle with offset 0,
//   line 1 and column 1.
// ----------------------------------------------------------------------------
module source_byte_tokenizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  sbt_pkg::t_in  i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output sbt_pkg::t_out o_out_data,
    input  logic          i_out_stall
);

    typedef enum logic [3:0] {
        M_IDLE, M_OP, M_STRING, M_COMMENT, M_INT, M_DOT, M_FRAC, M_BADNUM, M_IDENT
    } t_mode;

    localparam int OB = sbt_pkg::OFFSET_BITS;
    localparam int CB = sbt_pkg::COUNT_BITS;

    // Lexer state.
    t_mode             r_mode, n_mode;
    logic [7:0]        r_pend_op, n_pend_op;
    logic [OB-1:0]     r_tok_start, n_tok_start;
    logic [CB-1:0]     r_tok_line, n_tok_line;
    logic [CB-1:0]     r_tok_col, n_tok_col;
    logic [OB-1:0]     r_byte_pos, n_byte_pos;
    logic [CB-1:0]     r_cur_line, n_cur_line;
    logic [CB-1:0]     r_cur_col, n_cur_col;
    sbt_pkg::t_word    r_word, n_word;
    logic [CB-1:0]     r_word_len, n_word_len;
    logic [2:0]        r_num_err, n_num_err;

    // Output queue.
    sbt_pkg::t_out     r_fifo [4];
    logic [1:0]        r_wr_ptr, r_rd_ptr;
    logic [2:0]        r_count;

    logic              in_xfer, out_xfer;
    logic [7:0]        c;
    logic              eoi, numtail, done;
    logic              pend_v, idle_v;
    sbt_pkg::t_out     pend_t, idle_t;
    logic [1:0]        push_n;
    sbt_pkg::t_out     item0, item1;
    logic [CB-1:0]     len_inc;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_xfer    = o_out_valid && !i_out_stall;
    assign o_in_stall  = (r_count > 3'd2);
    assign o_out_valid = (r_count != 3'd0);
    assign o_out_data  = r_fifo[r_rd_ptr];

    assign eoi     = i_in_data.end_of_input;
    assign c       = eoi ? sbt_pkg::CH_NUL : i_in_data.char_byte;
    assign numtail = sbt_pkg::is_word(c) || (c == sbt_pkg::CH_DOT);
    assign len_inc = (r_word_len == '1) ? r_word_len : r_word_len + CB'(1);

    // Next lexer state and the tokens caused by this byte.
    always_comb begin
        n_mode     = r_mode;
        n_pend_op  = r_pend_op;
        n_tok_start = r_tok_start;
        n_tok_line = r_tok_line;
        n_tok_col  = r_tok_col;
        n_byte_pos = r_byte_pos;
        n_cur_line = r_cur_line;
        n_cur_col  = r_cur_col;
        n_word     = r_word;
        n_word_len = r_word_len;
        n_num_err  = r_num_err;
        done       = 1'b0;
        pend_v     = 1'b0;
        idle_v     = 1'b0;
        pend_t     = '{token_kind: sbt_pkg::K_NONE, start_offset: r_tok_start,
                       text_length: r_word_len, line: r_tok_line, column: r_tok_col,
                       error_code: sbt_pkg::E_NONE, last_of_run: 1'b0};
        idle_t     = '{token_kind: sbt_pkg::K_NONE, start_offset: r_byte_pos,
                       text_length: CB'(1), line: r_cur_line, column: r_cur_col,
                       error_code: sbt_pkg::E_NONE, last_of_run: 1'b0};

        // Pending token handling.
        unique case (r_mode)
            M_OP: begin
                pend_v = 1'b1;
                if (c == sbt_pkg::CH_EQ) begin
                    pend_t.token_kind  = sbt_pkg::op_kind(r_pend_op) + 6'd1;
                    pend_t.text_length = CB'(2);
                    done = 1'b1;
                end else begin
                    pend_t.token_kind = sbt_pkg::op_kind(r_pend_op);
                end
            end
            M_STRING: begin
                if (c == sbt_pkg::CH_QUOTE) begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::K_STRING;
                    done = 1'b1;
                end else if (c == sbt_pkg::CH_NUL || c == sbt_pkg::CH_LF) begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::K_UNKNOWN;
                    pend_t.error_code = sbt_pkg::E_UNTERM;
                end else begin
                    n_word_len = len_inc;
                    done = 1'b1;
                end
            end
            M_COMMENT: begin
                if (c == sbt_pkg::CH_NUL || c == sbt_pkg::CH_LF) begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::K_COMMENT;
                end else begin
                    n_word_len = len_inc;
                    done = 1'b1;
                end
            end
            M_INT, M_FRAC: begin
                if (sbt_pkg::is_digit(c)) begin
                    done = 1'b1;
                end else if (c == sbt_pkg::CH_DOT && r_mode == M_INT) begin
                    n_mode = M_DOT;
                    done = 1'b1;
                end else if (numtail) begin
                    n_mode = M_BADNUM;
                    n_num_err = sbt_pkg::E_NUMBER;
                    done = 1'b1;
                end else begin
                    pend_v = 1'b1;
                    pend_t.token_kind = (r_mode == M_INT) ? sbt_pkg::K_INT : sbt_pkg::K_FLOAT;
                end
                if (done) begin
                    n_word_len = len_inc;
                end
            end
            M_DOT: begin
                n_num_err = sbt_pkg::E_DOT;
                if (sbt_pkg::is_digit(c)) begin
                    n_mode = M_FRAC;
                    done = 1'b1;
                end else if (numtail) begin
                    n_mode = M_BADNUM;
                    done = 1'b1;
                end else begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::K_UNKNOWN;
                    pend_t.error_code = sbt_pkg::E_DOT;
                end
                if (done) begin
                    n_word_len = len_inc;
                end
            end
            M_BADNUM: begin
                if (numtail) begin
                    n_word_len = len_inc;
                    done = 1'b1;
                end else begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::K_UNKNOWN;
                    pend_t.error_code = r_num_err;
                end
            end
            M_IDENT: begin
                if (sbt_pkg::is_word(c)) begin
                    if (r_word_len < CB'(sbt_pkg::KEYWORD_CHARS)) begin
                        n_word[r_word_len[sbt_pkg::WIDX_BITS-1:0]] = c;
                    end
                    n_word_len = len_inc;
                    done = 1'b1;
                end else begin
                    pend_v = 1'b1;
                    pend_t.token_kind = sbt_pkg::word_kind(r_word, r_word_len);
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        if (pend_v) begin
            n_mode = M_IDLE;
        end

        // Byte lexed from idle.
        if (!done) begin
            priority if (c == sbt_pkg::CH_SPACE || c == sbt_pkg::CH_TAB) begin
                idle_v = 1'b0;
            end else if (c == sbt_pkg::CH_NUL) begin
                idle_v = 1'b1;
                idle_t.token_kind  = sbt_pkg::K_EOF;
                idle_t.text_length = '0;
            end else if (sbt_pkg::punct_kind(c) != sbt_pkg::K_NONE) begin
                idle_v = 1'b1;
                idle_t.token_kind = sbt_pkg::punct_kind(c);
            end else if (sbt_pkg::op_kind(c) != sbt_pkg::K_NONE
                         || c == sbt_pkg::CH_QUOTE || c == sbt_pkg::CH_HASH
                         || sbt_pkg::is_word(c)) begin
                n_tok_start = r_byte_pos;
                n_tok_line  = r_cur_line;
                n_tok_col   = r_cur_col;
                n_word_len  = CB'(1);
                priority if (sbt_pkg::op_kind(c) != sbt_pkg::K_NONE) begin
                    n_pend_op = c;
                    n_mode = M_OP;
                end else if (c == sbt_pkg::CH_QUOTE) begin
                    n_mode = M_STRING;
                    n_word_len = '0;
                    n_tok_start = (r_byte_pos == '1) ? r_byte_pos : r_byte_pos + OB'(1);
                end else if (c == sbt_pkg::CH_HASH) begin
                    n_mode = M_COMMENT;
                end else if (sbt_pkg::is_digit(c)) begin
                    n_mode = M_INT;
                end else begin
                    n_mode = M_IDENT;
                    n_word[0] = c;
                end
            end else begin
                idle_v = 1'b1;
                idle_t.token_kind = sbt_pkg::K_UNKNOWN;
                idle_t.error_code = sbt_pkg::E_CHAR;
            end
        end

        // Position counters.
        if (!eoi) begin
            n_byte_pos = (r_byte_pos == '1) ? r_byte_pos : r_byte_pos + OB'(1);
            if (c == sbt_pkg::CH_LF) begin
                n_cur_line = (r_cur_line == '1) ? r_cur_line : r_cur_line + CB'(1);
                n_cur_col  = CB'(1);
            end else begin
                n_cur_col  = (r_cur_col == '1) ? r_cur_col : r_cur_col + CB'(1);
            end
        end
    end

    // Order the tokens of this byte and mark the last one.
    always_comb begin
        push_n = {1'b0, pend_v} + {1'b0, idle_v};
        item0  = pend_v ? pend_t : idle_t;
        item1  = idle_t;
        if (push_n == 2'd1) begin
            item0.last_of_run = 1'b1;
        end
        item1.last_of_run = 1'b1;
    end

    // Lexer state and output queue.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= M_IDLE;
            r_pend_op   <= '0;
            r_tok_start <= '0;
            r_tok_line  <= CB'(1);
            r_tok_col   <= CB'(1);
            r_byte_pos  <= '0;
            r_cur_line  <= CB'(1);
            r_cur_col   <= CB'(1);
            r_word_len  <= '0;
            r_num_err   <= sbt_pkg::E_NONE;
            r_wr_ptr    <= '0;
            r_rd_ptr    <= '0;
            r_count     <= '0;
        end else begin
            if (in_xfer) begin
                r_mode      <= n_mode;
                r_pend_op   <= n_pend_op;
                r_tok_start <= n_tok_start;
                r_tok_line  <= n_tok_line;
                r_tok_col   <= n_tok_col;
                r_byte_pos  <= n_byte_pos;
                r_cur_line  <= n_cur_line;
                r_cur_col   <= n_cur_col;
                r_word_len  <= n_word_len;
                r_num_err   <= n_num_err;
                r_wr_ptr    <= r_wr_ptr + push_n;
            end
            if (out_xfer) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            r_count <= r_count + (in_xfer ? {1'b0, push_n} : 3'd0) - {2'b0, out_xfer};
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_word <= n_word;
            if (push_n != 2'd0) begin
                r_fifo[r_wr_ptr] <= item0;
            end
            if (push_n == 2'd2) begin
                r_fifo[r_wr_ptr + 2'd1] <= item1;
            end
        end
    end

    // Checks.
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 3'd4)
        else $error("output queue overflow");

    a_eoi_holds_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.end_of_input) |=> $stable(r_byte_pos))
        else $error("end of input moved the byte offset");

    a_newline_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && !i_in_data.end_of_input && i_in_data.char_byte == sbt_pkg::CH_LF)
        |=> (r_cur_col == CB'(1)))
        else $error("newline did not reset the column");

endmodule
